// ===== design/spncbc_pkg.sv =====
// Shared widths, register codes and round functions of the CBC block cipher core.
package spncbc_pkg;

  localparam int BLOCK_W = 32;
  localparam int NIB_W   = 4;
  localparam int NIB_N   = BLOCK_W / NIB_W;
  localparam int ROUNDS  = 4;

  // Configuration register codes
  typedef enum logic [0:0] {
    CFG_KEY = 1'b0,
    CFG_IV  = 1'b1
  } cfg_idx_t;

  typedef logic [BLOCK_W-1:0] block_t;

  localparam logic [NIB_W-1:0] SBOX [16] = '{
    4'd10, 4'd0, 4'd9, 4'd14, 4'd6, 4'd3, 4'd15, 4'd5,
    4'd1, 4'd13, 4'd12, 4'd7, 4'd11, 4'd4, 4'd2, 4'd8
  };

  // Replace every nibble through the S-box
  function automatic block_t sub_nibbles(block_t x);
    block_t r;
    r = '0;
    for (int k = 0; k < NIB_N; k++) begin
      r[NIB_W*k +: NIB_W] = SBOX[x[NIB_W*k +: NIB_W]];
    end
    return r;
  endfunction

  // Wire permutation, bits numbered from the MSB: out bit i = in bit (29i+31) mod 32
  function automatic block_t perm_bits(block_t x);
    block_t     r;
    logic [4:0] src;
    r   = '0;
    src = '0;
    for (int i = 0; i < BLOCK_W; i++) begin
      src = 5'(29 * i + 31);
      r[BLOCK_W-1-i] = x[5'd31 - src];
    end
    return r;
  endfunction

endpackage

// ===== design/spncbc_round.sv =====
// One cipher round: key mix, nibble substitution and bit permutation.
module spncbc_round (
  input  spncbc_pkg::block_t state_i,
  input  spncbc_pkg::block_t key_i,
  output spncbc_pkg::block_t state_o
);
  import spncbc_pkg::*;

  // Mix key, substitute, permute
  assign state_o = perm_bits(sub_nibbles(state_i ^ key_i));

endmodule

// ===== design/spncbc_core.sv =====
// Unrolled round chain with final key whitening.
module spncbc_core (
  input  spncbc_pkg::block_t block_i,
  input  spncbc_pkg::block_t key_i,
  output spncbc_pkg::block_t block_o
);
  import spncbc_pkg::*;

  block_t stage_w [ROUNDS+1];

  assign stage_w[0] = block_i;

  // Chain the rounds
  for (genvar g = 0; g < ROUNDS; g++) begin : g_round
    spncbc_round u_round (
      .state_i (stage_w[g]),
      .key_i   (key_i),
      .state_o (stage_w[g+1])
    );
  end

  // Whiten the result
  assign block_o = stage_w[ROUNDS] ^ key_i;

endmodule

// ===== design/spn_block_cipher_cbc_encrypt_core.sv =====
// Requests pass the input register, then the result register, whose valid drives out_valid.
// Throughput: one block per cycle unless out_ready stalls; all rounds are unrolled between
// the two registers. The chaining value, unless in_hold_chain was set, is updated on the
// same edge that loads the result register.
// Reset (synchronous, active low): empties both stages and clears key, IV and chaining value.
// in_ready stays high while the input stage is empty or the result register is free or being taken.
module spn_block_cipher_cbc_encrypt_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  spncbc_pkg::cfg_idx_t cfg_index,
  input  spncbc_pkg::block_t   cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  spncbc_pkg::block_t   in_plaintext_block,
  input  logic                 in_start_message,
  input  logic                 in_hold_chain,
  output logic                 out_valid,
  input  logic                 out_ready,
  output spncbc_pkg::block_t   out_ciphertext_block
);
  import spncbc_pkg::*;

  block_t key_r;
  block_t iv_r;
  block_t chain_r;
  block_t chain_nxt;

  logic   s1_valid_r;
  block_t s1_pt_r;
  logic   s1_start_r;
  logic   s1_hold_r;

  logic   out_valid_r;
  block_t out_ct_r;

  logic   out_free;
  logic   s1_move;
  logic   in_take;
  block_t chain_sel;
  block_t ct_w;

  // Handshake control
  assign out_free = !out_valid_r || out_ready;
  assign s1_move  = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || out_free;
  assign in_take  = in_valid && in_ready;

  // Select chaining value and encrypt
  assign chain_sel = s1_start_r ? iv_r : chain_r;

  spncbc_core u_core (
    .block_i (s1_pt_r ^ chain_sel),
    .key_i   (key_r),
    .block_o (ct_w)
  );

  assign chain_nxt = (s1_move && !s1_hold_r) ? ct_w : chain_r;

  // Configuration registers and chaining value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r   <= '0;
      iv_r    <= '0;
      chain_r <= '0;
    end else begin
      chain_r <= chain_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_KEY: key_r <= cfg_wdata;
          CFG_IV:  iv_r  <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // Input stage: hold request until it moves on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_pt_r    <= in_plaintext_block;
      s1_start_r <= in_start_message;
      s1_hold_r  <= in_hold_chain;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_ct_r <= ct_w;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_ciphertext_block = out_ct_r;

endmodule

// ===== design/spncbc_checker.sv =====
// Port-level checks of the CBC cipher core, bound to the top level.
module spncbc_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 cfg_we,
  input spncbc_pkg::cfg_idx_t cfg_index,
  input spncbc_pkg::block_t   cfg_wdata,
  input logic                 in_valid,
  input logic                 in_ready,
  input spncbc_pkg::block_t   in_plaintext_block,
  input logic                 in_start_message,
  input logic                 in_hold_chain,
  input logic                 out_valid,
  input logic                 out_ready,
  input spncbc_pkg::block_t   out_ciphertext_block
);

  // Reset empties both stages
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && in_ready))
    else $error("pipeline not empty after reset");

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_ciphertext_block)))
    else $error("stalled result changed");

  // Back-pressure only when the result is stuck
  a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without output back-pressure");

  // A taking consumer always frees the input side
  a_ready_pass: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input not ready while output drains");

endmodule

bind spn_block_cipher_cbc_encrypt_core spncbc_checker u_spncbc_checker (.*);
